FILE: rtl/sfpr_pkg.sv
// shared types, protocol codes and helpers for the serial flash programming responder
// no dependencies
package sfpr_pkg;

    localparam int unsigned PAGE_BYTES_DEF  = 128;
    localparam int unsigned FLASH_BYTES_DEF = 32768;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    // command bytes
    localparam logic [7:0] CMD_GET_PARAM   = 8'h41;
    localparam logic [7:0] CMD_SET_DEVICE  = 8'h42;
    localparam logic [7:0] CMD_SET_DEV_EXT = 8'h45;
    localparam logic [7:0] CMD_LEAVE_PROG  = 8'h51;
    localparam logic [7:0] CMD_LOAD_ADDR   = 8'h55;
    localparam logic [7:0] CMD_PROG_PAGE   = 8'h64;
    localparam logic [7:0] CMD_READ_PAGE   = 8'h74;
    localparam logic [7:0] CMD_READ_SIGN   = 8'h75;

    // reply and framing bytes
    localparam logic [7:0] RESP_OK     = 8'h10;
    localparam logic [7:0] RESP_INSYNC = 8'h14;
    localparam logic [7:0] RESP_NOSYNC = 8'h15;
    localparam logic [7:0] SYNC_EOP    = 8'h20;
    localparam logic [7:0] KIND_FLASH  = 8'h46;
    localparam logic [7:0] PARAM_HW    = 8'h80;
    localparam logic [7:0] PARAM_SW    = 8'h81;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIG_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROT_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HW_VER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SW_MAJOR  = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       start_application;
    } out_item_t;

    typedef enum logic [1:0] {
        TX_NOSYNC,
        TX_INSYNC,
        TX_PAYLOAD,
        TX_OK
    } tx_sel_t;

    typedef struct packed {
        logic        rx_store;
        logic        data_store;
        logic [4:0]  arg_idx;
        logic [7:0]  command;
        logic [15:0] bytes_left;
        logic [7:0]  rx_byte;
        logic        sweep_clr;
        logic        clear_en;
        logic        commit_en;
        logic        rc_clr;
        logic        rc_inc;
        logic        mem_read;
        logic        out_load;
        tx_sel_t     tx_sel;
        logic        start_app;
    } dp_cmd_t;

    typedef struct packed {
        logic        flash_last;
        logic        page_last;
        logic        commit_ok;
        logic        payload_more;
        logic        payload_mem;
        logic [15:0] transfer_length;
    } dp_status_t;

    function automatic logic [4:0] arg_count(input logic [7:0] c);
        logic [4:0] n;
        case (c)
            CMD_GET_PARAM:   n = 5'd1;
            CMD_SET_DEVICE:  n = 5'd20;
            CMD_SET_DEV_EXT: n = 5'd5;
            CMD_LOAD_ADDR:   n = 5'd2;
            CMD_PROG_PAGE:   n = 5'd3;
            CMD_READ_PAGE:   n = 5'd3;
            default:         n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/sfpr_dp.sv
// datapath: configuration registers, address and length fields, page buffer,
// program memory with clear and page commit sweeps, reply byte register; uses sfpr_pkg
module sfpr_dp #(
    parameter int unsigned PAGE_BYTES  = sfpr_pkg::PAGE_BYTES_DEF,
    parameter int unsigned FLASH_BYTES = sfpr_pkg::FLASH_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sfpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  sfpr_pkg::dp_cmd_t              cmd,
    output sfpr_pkg::dp_status_t           status,
    output sfpr_pkg::out_item_t            out_item
);

    localparam int unsigned AW = $clog2(FLASH_BYTES);
    localparam int unsigned PW = $clog2(PAGE_BYTES);

    logic [7:0]  sig_high_reg, sig_mid_reg, sig_low_reg, hw_ver_reg, sw_major_reg;
    logic [14:0] prot_lim_reg;
    logic [15:0] wa_reg, tl_reg, rc_reg;
    logic [7:0]  kind_reg, query_reg;
    logic [AW-1:0] sweep_reg;
    logic        wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    logic        wr_use_reg;
    logic [7:0]  ps_q_reg, mem_q_reg;
    sfpr_pkg::out_item_t out_reg;

    logic [7:0] page_store [PAGE_BYTES];
    logic [7:0] program_memory [FLASH_BYTES];

    logic [16:0]   wa_bytes;
    logic [AW-1:0] ba, rd_addr, wr_pos;
    logic [PW-1:0] off, k, pi;
    logic          in_range;
    logic [15:0]   data_idx;
    logic [17:0]   rd_sum;
    logic [7:0]    payload;
    logic          payload_more;

    assign wa_bytes  = {wa_reg, 1'b0};
    assign ba        = wa_bytes[AW-1:0];
    assign off       = ba[PW-1:0];
    assign k         = sweep_reg[PW-1:0];
    assign pi        = k - off;
    assign wr_pos    = {ba[AW-1:PW], k};
    assign in_range  = (tl_reg >= 16'(PAGE_BYTES)) || (16'(pi) < tl_reg);
    assign data_idx  = tl_reg - cmd.bytes_left;
    assign rd_sum    = 18'(wa_bytes) + 18'(rc_reg);
    assign rd_addr   = rd_sum[AW-1:0];

    assign status.flash_last      = (sweep_reg == AW'(FLASH_BYTES - 1));
    assign status.page_last       = (k == PW'(PAGE_BYTES - 1));
    assign status.commit_ok       = (cmd.command == sfpr_pkg::CMD_PROG_PAGE)
                                    && (kind_reg == sfpr_pkg::KIND_FLASH)
                                    && (wa_reg < {1'b0, prot_lim_reg});
    assign status.payload_more    = payload_more;
    assign status.payload_mem     = (cmd.command == sfpr_pkg::CMD_READ_PAGE);
    assign status.transfer_length = tl_reg;
    assign out_item               = out_reg;

    always_comb begin
        if (cmd.command == sfpr_pkg::CMD_GET_PARAM) begin
            payload_more = (rc_reg == 16'd0);
        end else if (cmd.command == sfpr_pkg::CMD_READ_SIGN) begin
            payload_more = (rc_reg < 16'd3);
        end else if (cmd.command == sfpr_pkg::CMD_READ_PAGE
                     && kind_reg == sfpr_pkg::KIND_FLASH) begin
            payload_more = (rc_reg < tl_reg);
        end else begin
            payload_more = 1'b0;
        end
    end

    always_comb begin
        if (cmd.command == sfpr_pkg::CMD_GET_PARAM) begin
            if (query_reg == sfpr_pkg::PARAM_HW) begin
                payload = hw_ver_reg;
            end else if (query_reg == sfpr_pkg::PARAM_SW) begin
                payload = sw_major_reg;
            end else begin
                payload = 8'h00;
            end
        end else if (cmd.command == sfpr_pkg::CMD_READ_SIGN) begin
            if (rc_reg == 16'd0) begin
                payload = sig_high_reg;
            end else if (rc_reg == 16'd1) begin
                payload = sig_mid_reg;
            end else begin
                payload = sig_low_reg;
            end
        end else begin
            payload = mem_q_reg;
        end
    end

    // control and field registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_high_reg <= 8'h1E;
            sig_mid_reg  <= 8'h95;
            sig_low_reg  <= 8'h0F;
            prot_lim_reg <= 15'd15872;
            hw_ver_reg   <= 8'd2;
            sw_major_reg <= 8'd1;
            wa_reg       <= '0;
            tl_reg       <= '0;
            kind_reg     <= '0;
            query_reg    <= '0;
            rc_reg       <= '0;
            sweep_reg    <= '0;
            wr_pend_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    sfpr_pkg::REG_SIG_HIGH: sig_high_reg <= cfg_wdata[7:0];
                    sfpr_pkg::REG_SIG_MID:  sig_mid_reg  <= cfg_wdata[7:0];
                    sfpr_pkg::REG_SIG_LOW:  sig_low_reg  <= cfg_wdata[7:0];
                    sfpr_pkg::REG_PROT_LIM: prot_lim_reg <= cfg_wdata;
                    sfpr_pkg::REG_HW_VER:   hw_ver_reg   <= cfg_wdata[7:0];
                    sfpr_pkg::REG_SW_MAJOR: sw_major_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (cmd.rx_store) begin
                case (cmd.command)
                    sfpr_pkg::CMD_GET_PARAM: query_reg <= cmd.rx_byte;
                    sfpr_pkg::CMD_LOAD_ADDR: begin
                        if (cmd.arg_idx == 5'd0) begin
                            wa_reg[7:0] <= cmd.rx_byte;
                        end else begin
                            wa_reg[15:8] <= cmd.rx_byte;
                        end
                    end
                    sfpr_pkg::CMD_PROG_PAGE, sfpr_pkg::CMD_READ_PAGE: begin
                        if (cmd.arg_idx == 5'd0) begin
                            tl_reg <= {cmd.rx_byte, 8'h00};
                        end else if (cmd.arg_idx == 5'd1) begin
                            tl_reg[7:0] <= cmd.rx_byte;
                        end else begin
                            kind_reg <= cmd.rx_byte;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.rc_clr) begin
                rc_reg <= '0;
            end else if (cmd.rc_inc) begin
                rc_reg <= rc_reg + 16'd1;
            end
            if (cmd.sweep_clr) begin
                sweep_reg <= '0;
            end else if (cmd.clear_en || cmd.commit_en) begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            wr_pend_reg <= cmd.commit_en;
        end
    end

    // commit pipeline and reply byte register
    always_ff @(posedge aclk) begin
        if (cmd.commit_en) begin
            wr_addr_reg <= wr_pos;
            wr_use_reg  <= in_range;
        end
        if (cmd.out_load) begin
            out_reg.start_application <= cmd.start_app;
            case (cmd.tx_sel)
                sfpr_pkg::TX_NOSYNC:  out_reg.tx_byte <= sfpr_pkg::RESP_NOSYNC;
                sfpr_pkg::TX_INSYNC:  out_reg.tx_byte <= sfpr_pkg::RESP_INSYNC;
                sfpr_pkg::TX_PAYLOAD: out_reg.tx_byte <= payload;
                default:              out_reg.tx_byte <= sfpr_pkg::RESP_OK;
            endcase
        end
    end

    // page buffer
    always_ff @(posedge aclk) begin
        if (cmd.data_store && data_idx < 16'(PAGE_BYTES)) begin
            page_store[data_idx[PW-1:0]] <= cmd.rx_byte;
        end
        if (cmd.commit_en) begin
            ps_q_reg <= page_store[pi];
        end
    end

    // program memory
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            program_memory[sweep_reg] <= 8'hFF;
        end else if (wr_pend_reg) begin
            program_memory[wr_addr_reg] <= wr_use_reg ? ps_q_reg : 8'hFF;
        end
        if (cmd.mem_read) begin
            mem_q_reg <= program_memory[rd_addr];
        end
    end

endmodule

FILE: rtl/sfpr_ctrl.sv
// controller: protocol parser, reply sequencer and sweep control
// uses sfpr_pkg; drives sfpr_dp through dp_cmd_t
module sfpr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sfpr_pkg::in_item_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  sfpr_pkg::dp_status_t  status,
    output sfpr_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_COMMIT,
        ST_DRAIN,
        ST_FETCH,
        ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ARGS,
        PH_DATA,
        PH_EOP,
        PH_REPLY
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        sync_lost_reg, sync_lost_next;
    logic [1:0]  step_reg, step_next;
    logic        accept;
    logic [4:0]  rx_args;

    assign s_ready = (state_reg == ST_RUN);
    assign m_valid = (state_reg == ST_SEND);
    assign accept  = s_valid && s_ready;
    assign rx_args = sfpr_pkg::arg_count(s_item.rx_byte);

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        command_next    = command_reg;
        bytes_left_next = bytes_left_reg;
        sync_lost_next  = sync_lost_reg;
        step_next       = step_reg;
        cmd             = '0;
        cmd.command     = command_reg;
        cmd.bytes_left  = bytes_left_reg;
        cmd.rx_byte     = s_item.rx_byte;
        cmd.arg_idx     = sfpr_pkg::arg_count(command_reg) - bytes_left_reg[4:0];
        cmd.tx_sel      = sfpr_pkg::TX_OK;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.flash_last) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (accept && !s_item.opcode) begin
                    case (phase_reg)
                        PH_IDLE: begin
                            command_next    = s_item.rx_byte;
                            bytes_left_next = 16'(rx_args);
                            phase_next      = (rx_args != 5'd0) ? PH_ARGS : PH_EOP;
                        end
                        PH_ARGS: begin
                            cmd.rx_store    = 1'b1;
                            bytes_left_next = bytes_left_reg - 16'd1;
                            if (bytes_left_reg == 16'd1) begin
                                if (command_reg == sfpr_pkg::CMD_PROG_PAGE
                                    && status.transfer_length != 16'd0) begin
                                    bytes_left_next = status.transfer_length;
                                    phase_next      = PH_DATA;
                                end else begin
                                    phase_next = PH_EOP;
                                end
                            end
                        end
                        PH_DATA: begin
                            cmd.data_store  = 1'b1;
                            bytes_left_next = bytes_left_reg - 16'd1;
                            if (bytes_left_reg == 16'd1) begin
                                phase_next = PH_EOP;
                            end
                        end
                        PH_EOP: begin
                            sync_lost_next = (s_item.rx_byte != sfpr_pkg::SYNC_EOP);
                            step_next      = 2'd0;
                            cmd.rc_clr     = 1'b1;
                            phase_next     = PH_REPLY;
                            if (status.commit_ok) begin
                                cmd.sweep_clr = 1'b1;
                                state_next    = ST_COMMIT;
                            end
                        end
                        default: ;
                    endcase
                end else if (accept && phase_reg == PH_REPLY) begin
                    if (step_reg == 2'd0 && sync_lost_reg) begin
                        cmd.out_load = 1'b1;
                        cmd.tx_sel   = sfpr_pkg::TX_NOSYNC;
                        step_next    = 2'd1;
                        state_next   = ST_SEND;
                    end else if (step_reg != 2'd2) begin
                        cmd.out_load = 1'b1;
                        cmd.tx_sel   = sfpr_pkg::TX_INSYNC;
                        cmd.rc_clr   = 1'b1;
                        step_next    = 2'd2;
                        state_next   = ST_SEND;
                    end else if (status.payload_more) begin
                        cmd.rc_inc = 1'b1;
                        if (status.payload_mem) begin
                            cmd.mem_read = 1'b1;
                            state_next   = ST_FETCH;
                        end else begin
                            cmd.out_load = 1'b1;
                            cmd.tx_sel   = sfpr_pkg::TX_PAYLOAD;
                            state_next   = ST_SEND;
                        end
                    end else begin
                        cmd.out_load   = 1'b1;
                        cmd.tx_sel     = sfpr_pkg::TX_OK;
                        cmd.start_app  = (command_reg == sfpr_pkg::CMD_LEAVE_PROG);
                        phase_next     = PH_IDLE;
                        step_next      = 2'd0;
                        sync_lost_next = 1'b0;
                        state_next     = ST_SEND;
                    end
                end
            end
            ST_COMMIT: begin
                cmd.commit_en = 1'b1;
                if (status.page_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // last buffered write lands here
            ST_DRAIN: state_next = ST_RUN;
            ST_FETCH: begin
                cmd.out_load = 1'b1;
                cmd.tx_sel   = sfpr_pkg::TX_PAYLOAD;
                state_next   = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_IDLE;
            command_reg    <= '0;
            bytes_left_reg <= '0;
            sync_lost_reg  <= 1'b0;
            step_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            command_reg    <= command_next;
            bytes_left_reg <= bytes_left_next;
            sync_lost_reg  <= sync_lost_next;
            step_reg       <= step_next;
        end
    end

endmodule

FILE: rtl/serial_flash_programming_responder_top.sv
// top level of the serial flash programming responder
// instantiates sfpr_ctrl and sfpr_dp; uses sfpr_pkg
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_data (opcode, rx_byte)
//   m_        out        m_valid/m_ready    m_data (tx_byte, start_application)
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// one item at a time: a reply byte is loaded into the output register and shown in ST_SEND
// (a program memory byte passes ST_FETCH first, for the registered memory read)
// a flash page commit holds s_ready low through ST_COMMIT and ST_DRAIN (one byte per cycle)
// after reset the program memory is erased in a pass over all FLASH_BYTES (ST_CLEAR), s_ready low
// a reply byte waits in the output register until m_ready; no new item is taken meanwhile
// sizes are powers of two
module serial_flash_programming_responder_top #(
    parameter int unsigned PAGE_BYTES  = sfpr_pkg::PAGE_BYTES_DEF,
    parameter int unsigned FLASH_BYTES = sfpr_pkg::FLASH_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sfpr_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sfpr_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [sfpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    sfpr_pkg::dp_cmd_t    cmd;
    sfpr_pkg::dp_status_t status;

    sfpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sfpr_dp #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FLASH_BYTES (FLASH_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_item  (m_data)
    );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// testbench for serial_flash_programming_responder_top: drives protocol packets and
// transmit slots, predicts every reply byte and compares; depends on sfpr_pkg and the rtl
module tb;

    localparam int PAGE  = int'(sfpr_pkg::PAGE_BYTES_DEF);
    localparam int FLASH = int'(sfpr_pkg::FLASH_BYTES_DEF);
    localparam int LIMIT = 1000000;

    typedef enum logic [2:0] {ST_IDLE, ST_ARGS, ST_DATA, ST_EOP, ST_REPLY} parse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sfpr_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sfpr_pkg::out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    serial_flash_programming_responder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // responder state as the testbench sees it
    parse_t      rp_phase = ST_IDLE;
    logic [7:0]  rp_cmd = '0, rp_kind = '0, rp_query = '0;
    logic [15:0] rp_left = '0, rp_len = '0, rp_addr = '0, rp_sent = '0;
    logic [2:0]  rp_step = '0;
    logic        rp_nosync = 1'b0;
    logic [7:0]  rp_page [PAGE];
    logic [7:0]  rp_flash [FLASH];
    logic [7:0]  sig_bytes [3] = '{8'h1E, 8'h95, 8'h0F};
    logic [14:0] prot_limit = 15'd15872;
    logic [7:0]  hw_ver = 8'd2, sw_major = 8'd1;

    sfpr_pkg::out_item_t reply_q [$];
    int fails = 0;
    int items_sent = 0;
    int cycles = 0;
    int tx_idle_pct = 26;
    int rx_idle_pct = 78;
    int inject_pct = 5;

    initial for (int i = 0; i < FLASH; i++) rp_flash[i] = 8'hFF;

    function automatic int args_of(logic [7:0] c);
        case (c)
            sfpr_pkg::CMD_GET_PARAM:   return 1;
            sfpr_pkg::CMD_SET_DEVICE:  return 20;
            sfpr_pkg::CMD_SET_DEV_EXT: return 5;
            sfpr_pkg::CMD_LOAD_ADDR:   return 2;
            sfpr_pkg::CMD_PROG_PAGE:   return 3;
            sfpr_pkg::CMD_READ_PAGE:   return 3;
            default:                   return 0;
        endcase
    endfunction

    function automatic void burn_page();
        int ba, off, base, n;
        if (rp_addr >= {1'b0, prot_limit}) return;
        ba = (int'(rp_addr) * 2) % FLASH;
        off = ba % PAGE;
        base = ba - off;
        for (int k = 0; k < PAGE; k++) rp_flash[base + k] = 8'hFF;
        n = (rp_len > PAGE) ? PAGE : int'(rp_len);
        for (int i = 0; i < n; i += 2) begin
            rp_flash[base + (off + i) % PAGE] = rp_page[i];
            // odd length leaves the last high byte erased
            rp_flash[base + (off + i + 1) % PAGE] = (i + 1 < n) ? rp_page[i + 1] : 8'hFF;
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int idx;
        case (rp_phase)
            ST_IDLE: begin
                rp_cmd = b;
                rp_left = 16'(args_of(b));
                rp_phase = (rp_left != 0) ? ST_ARGS : ST_EOP;
            end
            ST_ARGS: begin
                idx = args_of(rp_cmd) - int'(rp_left);
                if (rp_cmd == sfpr_pkg::CMD_GET_PARAM) rp_query = b;
                else if (rp_cmd == sfpr_pkg::CMD_LOAD_ADDR) begin
                    if (idx == 0) rp_addr[7:0] = b;
                    else rp_addr[15:8] = b;
                end else if (rp_cmd == sfpr_pkg::CMD_PROG_PAGE
                             || rp_cmd == sfpr_pkg::CMD_READ_PAGE) begin
                    if (idx == 0) rp_len = {b, 8'h00};
                    else if (idx == 1) rp_len[7:0] = b;
                    else rp_kind = b;
                end
                rp_left--;
                if (rp_left == 0) begin
                    if (rp_cmd == sfpr_pkg::CMD_PROG_PAGE && rp_len != 0) begin
                        rp_left = rp_len;
                        rp_phase = ST_DATA;
                    end else rp_phase = ST_EOP;
                end
            end
            ST_DATA: begin
                idx = int'(rp_len) - int'(rp_left);
                if (idx < PAGE) rp_page[idx] = b;
                rp_left--;
                if (rp_left == 0) rp_phase = ST_EOP;
            end
            ST_EOP: begin
                rp_nosync = (b != sfpr_pkg::SYNC_EOP);
                if (rp_cmd == sfpr_pkg::CMD_PROG_PAGE && rp_kind == sfpr_pkg::KIND_FLASH)
                    burn_page();
                rp_step = 0;
                rp_sent = 0;
                rp_phase = ST_REPLY;
            end
            default: ;
        endcase
    endfunction

    function automatic int payload_len();
        if (rp_cmd == sfpr_pkg::CMD_GET_PARAM) return 1;
        if (rp_cmd == sfpr_pkg::CMD_READ_SIGN) return 3;
        if (rp_cmd == sfpr_pkg::CMD_READ_PAGE && rp_kind == sfpr_pkg::KIND_FLASH)
            return int'(rp_len);
        return 0;
    endfunction

    function automatic logic [7:0] payload_byte();
        if (rp_cmd == sfpr_pkg::CMD_GET_PARAM)
            return (rp_query == sfpr_pkg::PARAM_HW) ? hw_ver
                 : (rp_query == sfpr_pkg::PARAM_SW) ? sw_major : 8'h00;
        if (rp_cmd == sfpr_pkg::CMD_READ_SIGN)
            return sig_bytes[(rp_sent > 2) ? 2 : int'(rp_sent)];
        return rp_flash[(int'(rp_addr) * 2 + int'(rp_sent)) % FLASH];
    endfunction

    // returns 1 when a transmit slot yields a reply byte
    function automatic bit next_reply(output sfpr_pkg::out_item_t o);
        o = '0;
        if (rp_phase != ST_REPLY) return 0;
        if (rp_step == 0) begin
            rp_step = 1;
            if (rp_nosync) begin
                o.tx_byte = sfpr_pkg::RESP_NOSYNC;
                return 1;
            end
        end
        if (rp_step == 1) begin
            rp_step = 2;
            rp_sent = 0;
            o.tx_byte = sfpr_pkg::RESP_INSYNC;
            return 1;
        end
        if (rp_step == 2) begin
            if (int'(rp_sent) < payload_len()) begin
                o.tx_byte = payload_byte();
                rp_sent++;
                return 1;
            end
            rp_step = 3;
        end
        o.tx_byte = sfpr_pkg::RESP_OK;
        o.start_application = (rp_cmd == sfpr_pkg::CMD_LEAVE_PROG);
        rp_phase = ST_IDLE;
        rp_step = 0;
        rp_nosync = 1'b0;
        return 1;
    endfunction

    task automatic send(input logic op, input logic [7:0] b);
        sfpr_pkg::out_item_t o;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{opcode: op, rx_byte: b};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == 1'b0) begin
            if (rp_phase != ST_REPLY) take_byte(b);
        end else if (next_reply(o)) reply_q.push_back(o);
    endtask

    task automatic drain_reply();
        while (rp_phase == ST_REPLY) begin
            // bytes arriving mid-reply are dropped
            if ($urandom_range(0, 99) < inject_pct) send(1'b0, 8'($urandom));
            else send(1'b1, 8'($urandom));
        end
    endtask

    task automatic packet(input logic [7:0] bytes [$], input logic [7:0] eop);
        foreach (bytes[i]) send(1'b0, bytes[i]);
        send(1'b0, eop);
        drain_reply();
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (PAGE + 20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sfpr_pkg::CFG_IDX_W-1:0] idx, input logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sfpr_pkg::REG_SIG_HIGH: sig_bytes[0] = v[7:0];
            sfpr_pkg::REG_SIG_MID:  sig_bytes[1] = v[7:0];
            sfpr_pkg::REG_SIG_LOW:  sig_bytes[2] = v[7:0];
            sfpr_pkg::REG_PROT_LIM: prot_limit = v;
            sfpr_pkg::REG_HW_VER:   hw_ver = v[7:0];
            sfpr_pkg::REG_SW_MAJOR: sw_major = v[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_addr(input logic [15:0] a);
        packet('{sfpr_pkg::CMD_LOAD_ADDR, a[7:0], a[15:8]}, sfpr_pkg::SYNC_EOP);
    endtask

    task automatic prog_page(input int len, input logic [7:0] kind, input logic [7:0] eop);
        logic [7:0] bytes [$];
        bytes = '{sfpr_pkg::CMD_PROG_PAGE, 8'(len >> 8), 8'(len), kind};
        for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
        packet(bytes, eop);
    endtask

    task automatic read_page(input int len, input logic [7:0] kind);
        packet('{sfpr_pkg::CMD_READ_PAGE, 8'(len >> 8), 8'(len), kind}, sfpr_pkg::SYNC_EOP);
    endtask

    task automatic test_directed();
        logic [7:0] skip [$];
        packet('{sfpr_pkg::CMD_READ_SIGN}, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_GET_PARAM, sfpr_pkg::PARAM_HW}, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_GET_PARAM, sfpr_pkg::PARAM_SW}, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_GET_PARAM, 8'hFF}, sfpr_pkg::SYNC_EOP);
        skip = '{sfpr_pkg::CMD_SET_DEVICE};
        repeat (20) skip.push_back(8'hFF);
        packet(skip, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_SET_DEV_EXT, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h01},
               sfpr_pkg::SYNC_EOP);
        load_addr(16'h0040);
        prog_page(PAGE, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        read_page(PAGE, sfpr_pkg::KIND_FLASH);
        // mid-page start, odd length
        load_addr(16'h0085);
        prog_page(37, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        load_addr(16'h0080);
        read_page(PAGE, sfpr_pkg::KIND_FLASH);
        // data beyond one page is dropped
        prog_page(PAGE + 9, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        read_page(PAGE, sfpr_pkg::KIND_FLASH);
        // eeprom kind writes and reads nothing
        prog_page(4, 8'h45, sfpr_pkg::SYNC_EOP);
        read_page(8, 8'h45);
        // missing end of packet still runs the command
        packet('{sfpr_pkg::CMD_READ_SIGN}, 8'hFF);
        prog_page(2, sfpr_pkg::KIND_FLASH, 8'h00);
        // protected area and wrapped reads
        load_addr(16'd15872);
        prog_page(8, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        read_page(8, sfpr_pkg::KIND_FLASH);
        load_addr(16'hFFFF);
        read_page(4, sfpr_pkg::KIND_FLASH);
        prog_page(0, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        send(1'b1, 8'h00);
        inject_pct = 60;
        packet('{sfpr_pkg::CMD_READ_SIGN}, sfpr_pkg::SYNC_EOP);
        inject_pct = 5;
        packet('{8'h30}, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_LEAVE_PROG}, sfpr_pkg::SYNC_EOP);
        settle();
    endtask

    task automatic test_config();
        write_reg(sfpr_pkg::REG_SIG_HIGH, 15'h00FF);
        write_reg(sfpr_pkg::REG_SIG_MID, 15'h0000);
        write_reg(sfpr_pkg::REG_SIG_LOW, 15'h00A5);
        write_reg(sfpr_pkg::REG_HW_VER, 15'h00FF);
        write_reg(sfpr_pkg::REG_SW_MAJOR, 15'h0000);
        write_reg(sfpr_pkg::REG_PROT_LIM, 15'h7FFF);
        write_reg(3'd6, 15'h7FFF);
        write_reg(3'd7, 15'h0000);
        packet('{sfpr_pkg::CMD_READ_SIGN}, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_GET_PARAM, sfpr_pkg::PARAM_HW}, sfpr_pkg::SYNC_EOP);
        packet('{sfpr_pkg::CMD_GET_PARAM, sfpr_pkg::PARAM_SW}, sfpr_pkg::SYNC_EOP);
        // word address past flash wraps onto low pages
        load_addr(16'd16400);
        prog_page(16, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        load_addr(16'd16);
        read_page(16, sfpr_pkg::KIND_FLASH);
        settle();
        write_reg(sfpr_pkg::REG_PROT_LIM, 15'd0);
        load_addr(16'd0);
        prog_page(8, sfpr_pkg::KIND_FLASH, sfpr_pkg::SYNC_EOP);
        read_page(8, sfpr_pkg::KIND_FLASH);
        settle();
        write_reg(sfpr_pkg::REG_PROT_LIM, 15'd16384);
        write_reg(sfpr_pkg::REG_HW_VER, 15'h005A);
        write_reg(sfpr_pkg::REG_SW_MAJOR, 15'h00C3);
        write_reg(sfpr_pkg::REG_SIG_HIGH, 15'h0001);
        write_reg(sfpr_pkg::REG_SIG_MID, 15'h0080);
    endtask

    // stray bytes never open a long transfer
    function automatic logic [7:0] tame(logic [7:0] b);
        if (rp_phase == ST_IDLE
            && (b == sfpr_pkg::CMD_PROG_PAGE || b == sfpr_pkg::CMD_READ_PAGE)) return 8'h30;
        if (rp_phase == ST_ARGS
            && (rp_cmd == sfpr_pkg::CMD_PROG_PAGE || rp_cmd == sfpr_pkg::CMD_READ_PAGE)
            && int'(rp_left) == 3) return 8'h00;
        return b;
    endfunction

    task automatic random_packet();
        logic [7:0] skip [$];
        logic [7:0] eop;
        int len;
        eop = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sfpr_pkg::SYNC_EOP;
        case ($urandom_range(0, 9))
            0: packet('{sfpr_pkg::CMD_GET_PARAM, ($urandom_range(0, 2) == 0) ? 8'($urandom)
                       : 8'($urandom_range(sfpr_pkg::PARAM_HW, sfpr_pkg::PARAM_SW))}, eop);
            1: begin
                skip = '{($urandom_range(0, 1) != 0) ? sfpr_pkg::CMD_SET_DEVICE
                                                     : sfpr_pkg::CMD_SET_DEV_EXT};
                repeat (args_of(skip[0])) skip.push_back(8'($urandom));
                packet(skip, eop);
            end
            2: packet('{sfpr_pkg::CMD_READ_SIGN}, eop);
            3: packet('{($urandom_range(0, 3) == 0) ? sfpr_pkg::CMD_LEAVE_PROG
                                                    : 8'($urandom_range(0, 63))}, eop);
            4, 5: load_addr(($urandom_range(0, 2) == 0) ? 16'($urandom)
                            : 16'($urandom_range(0, 16383)));
            6, 7: begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(129, 300)
                                                   : $urandom_range(0, PAGE);
                prog_page(len, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : sfpr_pkg::KIND_FLASH, eop);
            end
            default: begin
                len = ($urandom_range(0, 20) == 0) ? 256 : $urandom_range(0, 40);
                read_page(len, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : sfpr_pkg::KIND_FLASH);
            end
        endcase
    endtask

    task automatic test_random(input int n, input int tx_pct, input int rx_pct);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 12) begin
                if ($urandom_range(0, 1) != 0) send(1'b1, 8'($urandom));
                else send(1'b0, tame(8'($urandom)));
                drain_reply();
            end else random_packet();
        end
        settle();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("reply byte %h with nothing expected", m_data.tx_byte);
                    fails++;
                end else begin
                    if (m_data.tx_byte !== reply_q[0].tx_byte) begin
                        $error("tx_byte expected %h actual %h",
                               reply_q[0].tx_byte, m_data.tx_byte);
                        fails++;
                    end
                    if (m_data.start_application !== reply_q[0].start_application) begin
                        $error("start_application expected %b actual %b",
                               reply_q[0].start_application, m_data.start_application);
                        fails++;
                    end
                    void'(reply_q.pop_front());
                end
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_config();
        test_directed();
        test_random(230, 26, 78);
        write_reg(sfpr_pkg::REG_PROT_LIM, 15'd200);
        write_reg(sfpr_pkg::REG_SIG_LOW, 15'h0000);
        test_random(230, 78, 26);
        write_reg(sfpr_pkg::REG_PROT_LIM, 15'd15872);
        write_reg(sfpr_pkg::REG_SIG_HIGH, 15'h00FF);
        test_random(230, 0, 0);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
